// ----- rtl/fkc_pkg.sv -----
// Package for the filtered k-mer counter: shared types, character codes,
// configuration register indexes and a small helper function.
// No dependencies.
package fkc_pkg;

    localparam int BYTE_W = 8;
    localparam int PAT_W  = 64;
    localparam int DATA_W = 64;
    localparam int CIDX_W = 3;

    localparam logic [BYTE_W-1:0] CHAR_HEADER  = 8'h3E;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    localparam logic [3:0] MAX_AFFIX_BYTES = 4'd8;
    localparam logic [5:0] MAX_GAP_BYTES   = 6'd32;

    typedef enum logic [CIDX_W-1:0] {
        REG_PREFIX_BYTES   = 3'd0,
        REG_PREFIX_LENGTH  = 3'd1,
        REG_PREFIX_GAP     = 3'd2,
        REG_SUFFIX_BYTES   = 3'd3,
        REG_SUFFIX_LENGTH  = 3'd4,
        REG_SUFFIX_GAP     = 3'd5,
        REG_PATTERN_LENGTH = 3'd6
    } cfg_reg_t;

    // Control part of a search request as it moves down the cell chain.
    typedef struct packed {
        logic valid;
        logic done;
        logic is_new;
    } search_ctl_t;

    // Byte mask that covers the first len bytes of a pattern word.
    function automatic logic [PAT_W-1:0] byte_mask(input logic [3:0] len);
        logic [PAT_W-1:0] m;
        m = '0;
        for (int i = 0; i < PAT_W / BYTE_W; i++)
        begin
            if (4'(i) < len)
            begin
                m[i*BYTE_W +: BYTE_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/fkc_cell.sv -----
// One table cell of the k-mer counter: holds one pattern and its count and
// passes the search request on to the next cell. Depends on fkc_pkg.
module fkc_cell #(
    parameter int CELL_INDEX  = 0,
    parameter int IDX_W       = 10,
    parameter int USED_W      = 11,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [USED_W-1:0]         entries_used,
    input  logic [fkc_pkg::PAT_W-1:0] match_mask,
    input  fkc_pkg::search_ctl_t      ctl_in,
    input  logic [IDX_W-1:0]          idx_in,
    input  logic [fkc_pkg::PAT_W-1:0] pat_in,
    input  logic [COUNT_WIDTH-1:0]    cnt_in,
    output fkc_pkg::search_ctl_t      ctl_out,
    output logic [IDX_W-1:0]          idx_out,
    output logic [fkc_pkg::PAT_W-1:0] pat_out,
    output logic [COUNT_WIDTH-1:0]    cnt_out
);

    logic [fkc_pkg::PAT_W-1:0] entry_pat_reg;
    logic [COUNT_WIDTH-1:0]    entry_cnt_reg;
    logic [COUNT_WIDTH-1:0]    entry_cnt_inc;
    fkc_pkg::search_ctl_t      ctl_reg, ctl_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [fkc_pkg::PAT_W-1:0] pat_reg;
    logic [COUNT_WIDTH-1:0]    cnt_reg, cnt_next;
    logic                      searching, hit, append;

    assign searching = ctl_in.valid && !ctl_in.done;
    assign hit = searching && (USED_W'(CELL_INDEX) < entries_used)
                 && (((entry_pat_reg ^ pat_in) & match_mask) == '0);
    assign append = searching && (USED_W'(CELL_INDEX) == entries_used);
    assign entry_cnt_inc = (entry_cnt_reg == '1) ? entry_cnt_reg
                                                 : entry_cnt_reg + 1'b1;

    always_comb
    begin
        ctl_next = ctl_in;
        idx_next = idx_in;
        cnt_next = cnt_in;
        if (hit)
        begin
            ctl_next.done = 1'b1;
            idx_next      = IDX_W'(CELL_INDEX);
            cnt_next      = entry_cnt_inc;
        end
        else if (append)
        begin
            ctl_next.done   = 1'b1;
            ctl_next.is_new = 1'b1;
            idx_next        = IDX_W'(CELL_INDEX);
            cnt_next        = COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_reg <= idx_next;
            pat_reg <= pat_in;
            cnt_reg <= cnt_next;
            if (hit)
            begin
                entry_cnt_reg <= entry_cnt_inc;
            end
            else if (append)
            begin
                entry_pat_reg <= pat_in;
                entry_cnt_reg <= COUNT_WIDTH'(1);
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign idx_out = idx_reg;
    assign pat_out = pat_reg;
    assign cnt_out = cnt_reg;

endmodule

// ----- rtl/filtered_kmer_counter.sv -----
// Filtered k-mer counter. A byte that does not complete a matching window causes no stall.
// A matching window sends a search request down TABLE_ENTRIES cells, one cell per cycle
// while the output does not stall; the input stalls until the result of that request
// enters the output register. Reset (rst_n, asynchronous, active low) clears the header
// flag, the window fill, the entry count, the chain's request flags and the configuration,
// except the pattern length, which is set to 4; no clearing pass.
module filtered_kmer_counter #(
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int TABLE_ENTRIES     = 1024,
    parameter int COUNT_WIDTH       = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [fkc_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [fkc_pkg::DATA_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  stream_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [9:0]                  entry_index,
    output logic [63:0]                 pattern_value,
    output logic [31:0]                 occurrences,
    output logic                        is_new,
    output logic                        table_full
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam int OUT_IDX_W = 10;
    localparam int OUT_CNT_W = 32;
    localparam logic [3:0] MAX_PAT = 4'(MAX_PATTERN_BYTES);

    // Configuration registers.
    logic [63:0] prefix_bytes_reg, suffix_bytes_reg;
    logic [3:0]  prefix_length_reg, suffix_length_reg, pattern_length_reg;
    logic [5:0]  prefix_gap_reg, suffix_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_bytes_reg   <= '0;
            prefix_length_reg  <= '0;
            prefix_gap_reg     <= '0;
            suffix_bytes_reg   <= '0;
            suffix_length_reg  <= '0;
            suffix_gap_reg     <= '0;
            pattern_length_reg <= 4'd4;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fkc_pkg::REG_PREFIX_BYTES:   prefix_bytes_reg   <= cfg_data;
                fkc_pkg::REG_PREFIX_LENGTH:  prefix_length_reg  <= cfg_data[3:0];
                fkc_pkg::REG_PREFIX_GAP:     prefix_gap_reg     <= cfg_data[5:0];
                fkc_pkg::REG_SUFFIX_BYTES:   suffix_bytes_reg   <= cfg_data;
                fkc_pkg::REG_SUFFIX_LENGTH:  suffix_length_reg  <= cfg_data[3:0];
                fkc_pkg::REG_SUFFIX_GAP:     suffix_gap_reg     <= cfg_data[5:0];
                fkc_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Clamped window geometry. The window is at most 88 bytes long.
    logic [3:0] pl, sl, plen;
    logic [5:0] pg, sg;
    logic [6:0] total, pat_start, suf_start;

    always_comb
    begin
        pl = (prefix_length_reg > fkc_pkg::MAX_AFFIX_BYTES) ? fkc_pkg::MAX_AFFIX_BYTES
                                                           : prefix_length_reg;
        sl = (suffix_length_reg > fkc_pkg::MAX_AFFIX_BYTES) ? fkc_pkg::MAX_AFFIX_BYTES
                                                           : suffix_length_reg;
        pg = (prefix_gap_reg > fkc_pkg::MAX_GAP_BYTES) ? fkc_pkg::MAX_GAP_BYTES
                                                      : prefix_gap_reg;
        sg = (suffix_gap_reg > fkc_pkg::MAX_GAP_BYTES) ? fkc_pkg::MAX_GAP_BYTES
                                                      : suffix_gap_reg;
        plen = (pattern_length_reg > MAX_PAT) ? MAX_PAT : pattern_length_reg;
        if (plen == 4'd0)
        begin
            plen = 4'd1;
        end
        pat_start = 7'(pl) + 7'(pg);
        total     = pat_start + 7'(plen) + 7'(sg) + 7'(sl);
        suf_start = total - 7'(sl);
    end

    // Window front end. Instead of storing the whole window, each byte is
    // checked against the prefix or suffix as it arrives, and pattern bytes
    // are gathered into a word; the window is judged on its last byte.
    logic        header_reg, header_next;
    logic [6:0]  fill_reg, fill_next, fill_inc;
    logic        ok_reg, ok_next;
    logic [63:0] pat_reg, pat_next;
    logic [7:0]  lc_byte;
    logic [6:0]  pat_off, suf_off;
    logic        take_byte, judged, accept;
    logic        busy_reg, busy_next;
    logic        launch_valid_reg, launch_valid_next;
    logic [63:0] launch_pat_reg;

    assign accept = in_valid && !in_stall;
    assign in_stall = busy_reg;

    always_comb
    begin
        header_next = header_reg;
        take_byte   = 1'b0;
        if (stream_byte == fkc_pkg::CHAR_HEADER)
        begin
            header_next = 1'b1;
        end
        if (header_next)
        begin
            if (stream_byte == fkc_pkg::CHAR_NEWLINE)
            begin
                header_next = 1'b0;
            end
        end
        else if (stream_byte != fkc_pkg::CHAR_NEWLINE)
        begin
            take_byte = 1'b1;
        end

        lc_byte = stream_byte;
        if (stream_byte >= fkc_pkg::CHAR_UPPER_A && stream_byte <= fkc_pkg::CHAR_UPPER_Z)
        begin
            lc_byte = stream_byte + fkc_pkg::CASE_OFFSET;
        end

        ok_next  = (fill_reg == '0) ? 1'b1 : ok_reg;
        pat_next = (fill_reg == '0) ? '0 : pat_reg;
        pat_off  = fill_reg - pat_start;
        suf_off  = fill_reg - suf_start;
        if (fill_reg < 7'(pl) && lc_byte != prefix_bytes_reg[8*fill_reg[2:0] +: 8])
        begin
            ok_next = 1'b0;
        end
        if (fill_reg >= suf_start && fill_reg < total
            && lc_byte != suffix_bytes_reg[8*suf_off[2:0] +: 8])
        begin
            ok_next = 1'b0;
        end
        if (fill_reg >= pat_start && pat_off < 7'(plen))
        begin
            pat_next[8*pat_off[2:0] +: 8] = lc_byte;
        end

        fill_inc  = fill_reg + 7'd1;
        judged    = take_byte && (fill_inc >= total);
        fill_next = judged ? 7'd0 : fill_inc;
    end

    // Cell chain. The whole chain moves together unless the result at its
    // end cannot enter the output register.
    fkc_pkg::search_ctl_t      ctl_chain [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]          idx_chain [TABLE_ENTRIES+1];
    logic [63:0]               pat_chain [TABLE_ENTRIES+1];
    logic [COUNT_WIDTH-1:0]    cnt_chain [TABLE_ENTRIES+1];
    logic [USED_W-1:0]         used_reg, used_next;
    logic [63:0]               match_mask;
    logic                      advance, end_valid;

    assign match_mask = fkc_pkg::byte_mask(plen);
    assign end_valid  = ctl_chain[TABLE_ENTRIES].valid;
    assign advance    = !(end_valid && out_valid && out_stall);

    assign ctl_chain[0] = '{valid: launch_valid_reg, done: 1'b0, is_new: 1'b0};
    assign idx_chain[0] = '0;
    assign pat_chain[0] = launch_pat_reg;
    assign cnt_chain[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        fkc_cell #(
            .CELL_INDEX (g),
            .IDX_W      (IDX_W),
            .USED_W     (USED_W),
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .entries_used(used_reg),
            .match_mask  (match_mask),
            .ctl_in      (ctl_chain[g]),
            .idx_in      (idx_chain[g]),
            .pat_in      (pat_chain[g]),
            .cnt_in      (cnt_chain[g]),
            .ctl_out     (ctl_chain[g+1]),
            .idx_out     (idx_chain[g+1]),
            .pat_out     (pat_chain[g+1]),
            .cnt_out     (cnt_chain[g+1])
        );
    end

    // Result formatting at the end of the chain.
    logic [OUT_IDX_W-1:0] res_idx;
    logic [OUT_CNT_W-1:0] res_cnt;
    logic                 res_full, capture;

    if (IDX_W >= OUT_IDX_W)
    begin : g_idx_cut
        assign res_idx = idx_chain[TABLE_ENTRIES][OUT_IDX_W-1:0];
    end
    else
    begin : g_idx_ext
        assign res_idx = OUT_IDX_W'(idx_chain[TABLE_ENTRIES]);
    end

    if (COUNT_WIDTH >= OUT_CNT_W)
    begin : g_cnt_cut
        assign res_cnt = cnt_chain[TABLE_ENTRIES][OUT_CNT_W-1:0];
    end
    else
    begin : g_cnt_ext
        assign res_cnt = OUT_CNT_W'(cnt_chain[TABLE_ENTRIES]);
    end

    assign res_full = !ctl_chain[TABLE_ENTRIES].done;
    assign capture  = end_valid && advance;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic [63:0]          out_pat_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;
    logic                 out_new_reg, out_full_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (capture)
        begin
            out_valid_next = 1'b1;
        end

        busy_next         = busy_reg;
        launch_valid_next = launch_valid_reg;
        if (launch_valid_reg && advance)
        begin
            launch_valid_next = 1'b0;
        end
        if (capture)
        begin
            busy_next = 1'b0;
        end
        if (accept && judged && ok_next)
        begin
            busy_next         = 1'b1;
            launch_valid_next = 1'b1;
        end

        used_next = used_reg;
        if (capture && ctl_chain[TABLE_ENTRIES].is_new)
        begin
            used_next = used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg       <= 1'b0;
            fill_reg         <= '0;
            busy_reg         <= 1'b0;
            launch_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            used_reg         <= '0;
        end
        else
        begin
            if (accept)
            begin
                header_reg <= header_next;
                if (take_byte)
                begin
                    fill_reg <= fill_next;
                end
            end
            busy_reg         <= busy_next;
            launch_valid_reg <= launch_valid_next;
            out_valid_reg    <= out_valid_next;
            used_reg         <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && take_byte)
        begin
            ok_reg  <= ok_next;
            pat_reg <= pat_next;
        end
        if (accept && judged && ok_next)
        begin
            launch_pat_reg <= pat_next;
        end
        if (capture)
        begin
            out_pat_reg  <= pat_chain[TABLE_ENTRIES];
            out_full_reg <= res_full;
            out_new_reg  <= ctl_chain[TABLE_ENTRIES].is_new;
            out_idx_reg  <= res_full ? '0 : res_idx;
            out_cnt_reg  <= res_full ? '0 : res_cnt;
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_index   = out_idx_reg;
    assign pattern_value = out_pat_reg;
    assign occurrences   = out_cnt_reg;
    assign is_new        = out_new_reg;
    assign table_full    = out_full_reg;

`ifndef SYNTHESIS
    // A dropped pattern is only reported once every table entry is in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> used_reg == USED_W'(TABLE_ENTRIES))
        else $error("table_full reported while the table has room");

    // A result never both creates an entry and reports a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && table_full))
        else $error("result marked both new and full");

    // A request waiting to enter the chain always keeps the input stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        launch_valid_reg |-> busy_reg)
        else $error("search request in flight without input stall");

    // The entry count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");
`endif

endmodule
